[rtl/sok_pkg.sv]
package sok_pkg;

   localparam int DIM_W  = 6;   // row_count / col_count register width
   localparam int POS_W  = 11;  // spiral position width
   localparam int DATA_W = 32;  // element width
   localparam int IDX_W  = 5;   // load row / column index width
   localparam int BND_W  = 7;   // signed spiral bound, spans -1 .. 63

   localparam logic signed [BND_W-1:0] BND_ONE = BND_W'(1);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TOP,
      PH_RIGHT,
      PH_BOTTOM,
      PH_LEFT
   } walk_phase_type;

   typedef struct packed {
      logic             done;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
   } walk_status_type;

endpackage

[rtl/sok_walker.sv]
module sok_walker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sok_pkg::POS_W-1:0]  position,
   input  logic [sok_pkg::DIM_W-1:0]  row_count,
   input  logic [sok_pkg::DIM_W-1:0]  col_count,
   output sok_pkg::walk_status_type   status
);
   import sok_pkg::*;

   walk_phase_type phase_ff, phase_in;
   logic signed [BND_W-1:0] top_ff, top_in;
   logic signed [BND_W-1:0] bottom_ff, bottom_in;
   logic signed [BND_W-1:0] left_ff, left_in;
   logic signed [BND_W-1:0] right_ff, right_in;
   logic [POS_W-1:0] rem_ff, rem_in;

   logic signed [BND_W-1:0] len_h;
   logic signed [BND_W-1:0] len_v;
   logic signed [BND_W-1:0] len_sel;
   logic signed [BND_W-1:0] rem_lo;
   logic [POS_W-1:0] seg_len;
   logic len_pos;
   logic fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      top_ff    <= top_in;
      bottom_ff <= bottom_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      rem_ff    <= rem_in;
   end

   always_comb begin
      len_h   = right_ff - left_ff + BND_ONE;
      len_v   = bottom_ff - top_ff + BND_ONE;
      len_sel = (phase_ff inside {PH_TOP, PH_BOTTOM}) ? len_h : len_v;
      len_pos = !len_sel[BND_W-1] && (len_sel != '0);
      seg_len = len_pos ? POS_W'(len_sel[BND_W-2:0]) : '0;
      fits    = len_pos && (rem_ff <= seg_len);
      rem_lo  = signed'(rem_ff[BND_W-1:0]);

      phase_in    = phase_ff;
      top_in      = top_ff;
      bottom_in   = bottom_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      rem_in      = rem_ff;
      status.done = 1'b0;
      status.row  = '0;
      status.col  = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               top_in    = '0;
               left_in   = '0;
               bottom_in = signed'(BND_W'(row_count)) - BND_ONE;
               right_in  = signed'(BND_W'(col_count)) - BND_ONE;
               rem_in    = position;
               phase_in  = PH_TOP;
            end
         end
         PH_TOP: begin
            if (top_ff > bottom_ff || left_ff > right_ff) begin
               // spiral exhausted: fall back to the corner element
               status.done = 1'b1;
               phase_in    = PH_IDLE;
            end else if (fits) begin
               status.done = 1'b1;
               status.row  = top_ff[DIM_W-1:0];
               status.col  = DIM_W'(left_ff + rem_lo - BND_ONE);
               phase_in    = PH_IDLE;
            end else begin
               rem_in   = rem_ff - seg_len;
               top_in   = top_ff + BND_ONE;
               phase_in = PH_RIGHT;
            end
         end
         PH_RIGHT: begin
            if (fits) begin
               status.done = 1'b1;
               status.row  = DIM_W'(top_ff + rem_lo - BND_ONE);
               status.col  = right_ff[DIM_W-1:0];
               phase_in    = PH_IDLE;
            end else begin
               rem_in   = rem_ff - seg_len;
               right_in = right_ff - BND_ONE;
               phase_in = PH_BOTTOM;
            end
         end
         PH_BOTTOM: begin
            if (top_ff <= bottom_ff && fits) begin
               status.done = 1'b1;
               status.row  = bottom_ff[DIM_W-1:0];
               status.col  = DIM_W'(right_ff - rem_lo + BND_ONE);
               phase_in    = PH_IDLE;
            end else begin
               if (top_ff <= bottom_ff) begin
                  rem_in    = rem_ff - seg_len;
                  bottom_in = bottom_ff - BND_ONE;
               end
               phase_in = PH_LEFT;
            end
         end
         PH_LEFT: begin
            if (left_ff <= right_ff && fits) begin
               status.done = 1'b1;
               status.row  = DIM_W'(bottom_ff - rem_lo + BND_ONE);
               status.col  = left_ff[DIM_W-1:0];
               phase_in    = PH_IDLE;
            end else begin
               if (left_ff <= right_ff) begin
                  rem_in  = rem_ff - seg_len;
                  left_in = left_ff + BND_ONE;
               end
               phase_in = PH_TOP;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

endmodule

[rtl/spiral_order_kth_element_top.sv]
// Channel   Direction  Handshake             Carries
// req_*     in         req_tvalid/tready     load (tuser=0) or spiral query (tuser=1)
// rsp_*     out        rsp_tvalid/tready     element at the queried position
// csr_*     in         csr_we                row_count (index 0), col_count (index 1)
//
// A load writes the element memory directly when it is accepted.
// A query is accepted, then the walker steps through the spiral one side at a time;
// the step that finds the position issues the memory read, and the read data
// then moves into the output register once that register is free.
// Out-of-range positions skip the walk and read row 0, column 0 right away.
// Reset is synchronous; the element memory is not cleared. Requests stall while
// a query walks or waits for a held result to drain from the output register.
module spiral_order_kth_element_top #(
   parameter int MAX_DIM = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [4:0] row_index, [9:5] col_index, [41:10] elem_value, [52:42] position
   input  logic [55:0]                  req_tdata,
   // [0] opcode
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [31:0] result_value
   output logic [sok_pkg::DATA_W-1:0]   rsp_tdata,
   input  logic                         csr_we,
   input  logic                         csr_addr,
   input  logic [sok_pkg::DIM_W-1:0]    csr_wdata
);
   import sok_pkg::*;

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_RST = (MAX_DIM < 32) ? MAX_DIM : 32;

   logic [DATA_W-1:0] mem [DEPTH];

   ctrl_state_type state_ff, state_in;
   logic [DIM_W-1:0] row_count_ff, col_count_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0] row_index;
   logic [IDX_W-1:0] col_index;
   logic [DATA_W-1:0] elem_value;
   logic [POS_W-1:0] position;
   logic [2*DIM_W-1:0] total;
   logic accept;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic rd_en;
   logic [AW-1:0] rd_addr;
   logic walk_start;
   walk_status_type walk_status;

   assign row_index  = req_tdata[4:0];
   assign col_index  = req_tdata[9:5];
   assign elem_value = req_tdata[41:10];
   assign position   = req_tdata[52:42];
   assign total      = row_count_ff * col_count_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign wr_en   = accept && (req_tuser == OP_LOAD)
                    && (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
   assign wr_addr = AW'(int'(row_index) * MAX_DIM + int'(col_index));

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   sok_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (walk_start),
      .position  (position),
      .row_count (row_count_ff),
      .col_count (col_count_ff),
      .status    (walk_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DIM_W'(DIM_RST);
         col_count_ff <= DIM_W'(DIM_RST);
      end else if (csr_we) begin
         case (csr_addr)
            REG_ROW_COUNT: row_count_ff <= clamp_dim(csr_wdata);
            REG_COL_COUNT: col_count_ff <= clamp_dim(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= elem_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      walk_start   = 1'b0;
      rsp_data_in  = rsp_data_ff;
      // drop the held result once taken
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == OP_QUERY) begin
               if (position == '0 || position > POS_W'(total)) begin
                  rd_en    = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  walk_start = 1'b1;
                  state_in   = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (walk_status.done) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(int'(walk_status.row) * MAX_DIM + int'(walk_status.col));
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = rd_data_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
